// ===== rtl/wrr_pkg.sv =====
// Shared types, constants and helpers for the weighted round-robin scheduler.
package wrr_pkg;

    localparam int QUEUES      = 8;
    localparam int WEIGHT_BITS = 8;
    localparam int QIDX_W      = 3;
    localparam int NQ_W        = 4;
    localparam int CREDIT_W    = 8;
    localparam int CNT_W       = 64;
    localparam int WEIGHTS_W   = 64;

    localparam logic [NQ_W-1:0]      RESET_QUEUES  = NQ_W'(QUEUES);
    localparam logic [WEIGHTS_W-1:0] RESET_WEIGHTS = 64'h0101_0101_0101_0101;

    typedef enum logic
    {
        CMD_SCHEDULE = 1'b0,
        CMD_CLEAR    = 1'b1
    } sched_cmd_t;

    typedef enum logic
    {
        CFG_QUEUES_IN_USE = 1'b0,
        CFG_QUEUE_WEIGHTS = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        sched_cmd_t         cmd;
        logic [QUEUES-1:0]  ready_mask;
    } sched_t;

    typedef struct packed
    {
        logic                granted;
        logic [QIDX_W-1:0]   grant_queue;
        logic [NQ_W-1:0]     skips_now;
        logic [QIDX_W-1:0]   next_queue;
        logic [CREDIT_W-1:0] credit_left;
        logic [CNT_W-1:0]    advance_total;
        logic [CNT_W-1:0]    skip_total;
    } result_t;

    typedef struct packed
    {
        logic start;
        logic clear;
        logic visit;
        logic load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic              n_zero;
        logic              hit;
        logic [QIDX_W-1:0] n_last;
        logic              result_free;
    } dp_stat_t;

    function automatic logic [CREDIT_W-1:0] weight_of(input logic [WEIGHTS_W-1:0] weights,
                                                      input logic [QIDX_W-1:0]    q);
        logic [WEIGHT_BITS-1:0] w;
        w = weights[{q, 3'b000} +: WEIGHT_BITS];
        return (w == '0) ? CREDIT_W'(1) : CREDIT_W'(w);
    endfunction

endpackage

// ===== rtl/weighted_round_robin_queue_scheduler.sv =====
// Top level of the credit-based weighted round-robin queue scheduler.
// After a schedule transaction is accepted, ST_SCAN visits k queues (1 to min(queues_in_use, 8)),
// then ST_LOAD registers the result once the result register is free; a clear or no active queues
// goes straight to ST_LOAD. A new transaction is accepted only after the result is loaded.
// Reset (rst_n, async low): pointer 0, credit from queue 0 weight, counters 0,
// queues_in_use 8, all weights 1, no result pending.
module weighted_round_robin_queue_scheduler
    import wrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sched_valid,
    output logic                 sched_ready,
    input  sched_t               sched,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_index_t           cfg_index,
    input  logic [WEIGHTS_W-1:0] cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    wrr_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .sched_valid (sched_valid),
        .sched_cmd   (sched.cmd),
        .sched_ready (sched_ready),
        .stat        (dp_stat),
        .cmd         (dp_cmd)
    );

    wrr_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .ready_mask   (sched.ready_mask),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

// ===== rtl/wrr_ctrl.sv =====
// Controller state machine: accept a transaction, sequence queue visits, load the result.
module wrr_ctrl
    import wrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sched_valid,
    input  sched_cmd_t sched_cmd,
    output logic       sched_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_LOAD = 3'b100
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic [QIDX_W-1:0] visit_reg, visit_next;
    logic              accept;

    assign sched_ready = (state_reg == ST_IDLE);
    assign accept      = sched_valid && sched_ready;

    always_comb
    begin
        state_next = state_reg;
        visit_next = visit_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    cmd.clear  = (sched_cmd == CMD_CLEAR);
                    visit_next = '0;
                    if (sched_cmd == CMD_CLEAR || stat.n_zero)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.visit = 1'b1;
                if (stat.hit || visit_reg == stat.n_last)
                    state_next = ST_LOAD;
                else
                    visit_next = visit_reg + QIDX_W'(1);
            end
            ST_LOAD:
            begin
                cmd.load = stat.result_free;
                if (stat.result_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            visit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            visit_reg <= visit_next;
        end
    end

endmodule

// ===== rtl/wrr_dp.sv =====
// Datapath: configuration, pointer, credit, counters and result register.
module wrr_dp
    import wrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [QUEUES-1:0]    ready_mask,
    input  logic                 cfg_write,
    input  cfg_index_t           cfg_index,
    input  logic [WEIGHTS_W-1:0] cfg_data,
    output result_t              result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    logic [NQ_W-1:0]      qiu_reg;
    logic [WEIGHTS_W-1:0] weights_reg;
    logic [QIDX_W-1:0]    ptr_reg, ptr_next;
    logic [CREDIT_W-1:0]  credit_reg, credit_next;
    logic [CNT_W-1:0]     adv_reg, adv_next;
    logic [CNT_W-1:0]     skip_reg, skip_next;
    logic [QUEUES-1:0]    mask_reg, mask_next;
    logic                 granted_reg, granted_next;
    logic [QIDX_W-1:0]    grant_q_reg, grant_q_next;
    logic [NQ_W-1:0]      skips_reg, skips_next;
    result_t              result_reg;
    logic                 result_valid_reg;

    logic [NQ_W-1:0]      active_n;
    logic [NQ_W-1:0]      ptr_inc;
    logic [QIDX_W-1:0]    ptr_step;
    logic                 hit;

    assign active_n = (qiu_reg > NQ_W'(QUEUES)) ? NQ_W'(QUEUES) : qiu_reg;
    assign ptr_inc  = {1'b0, ptr_reg} + NQ_W'(1);
    assign ptr_step = (ptr_inc >= active_n) ? '0 : ptr_inc[QIDX_W-1:0];
    assign hit      = ({1'b0, ptr_reg} < active_n) && mask_reg[ptr_reg];

    assign stat.n_zero      = (active_n == '0);
    assign stat.hit         = hit;
    assign stat.n_last      = QIDX_W'(active_n - NQ_W'(1));
    assign stat.result_free = !result_valid_reg || result_ready;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        ptr_next     = ptr_reg;
        credit_next  = credit_reg;
        adv_next     = adv_reg;
        skip_next    = skip_reg;
        granted_next = granted_reg;
        grant_q_next = grant_q_reg;
        skips_next   = skips_reg;
        mask_next    = mask_reg;
        if (cmd.start)
        begin
            mask_next    = ready_mask;
            granted_next = 1'b0;
            grant_q_next = '0;
            skips_next   = '0;
        end
        if (cmd.clear)
        begin
            ptr_next    = '0;
            credit_next = (active_n == '0) ? '0 : weight_of(weights_reg, '0);
            adv_next    = '0;
            skip_next   = '0;
        end
        if (cmd.visit)
        begin
            if (hit)
            begin
                granted_next = 1'b1;
                grant_q_next = ptr_reg;
                adv_next     = adv_reg + CNT_W'(1);
                if (credit_reg > CREDIT_W'(1))
                begin
                    credit_next = credit_reg - CREDIT_W'(1);
                end
                else
                begin
                    ptr_next    = ptr_step;
                    credit_next = weight_of(weights_reg, ptr_step);
                end
            end
            else
            begin
                skips_next  = skips_reg + NQ_W'(1);
                skip_next   = skip_reg + CNT_W'(1);
                ptr_next    = ptr_step;
                credit_next = weight_of(weights_reg, ptr_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qiu_reg          <= RESET_QUEUES;
            weights_reg      <= RESET_WEIGHTS;
            ptr_reg          <= '0;
            credit_reg       <= weight_of(RESET_WEIGHTS, '0);
            adv_reg          <= '0;
            skip_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_QUEUES_IN_USE: qiu_reg     <= cfg_data[NQ_W-1:0];
                    CFG_QUEUE_WEIGHTS: weights_reg <= cfg_data;
                    default:           qiu_reg     <= qiu_reg;
                endcase
            end
            ptr_reg    <= ptr_next;
            credit_reg <= credit_next;
            adv_reg    <= adv_next;
            skip_reg   <= skip_next;
            if (cmd.load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        granted_reg <= granted_next;
        grant_q_reg <= grant_q_next;
        skips_reg   <= skips_next;
        if (cmd.load)
        begin
            result_reg.granted       <= granted_reg;
            result_reg.grant_queue   <= grant_q_reg;
            result_reg.skips_now     <= skips_reg;
            result_reg.next_queue    <= ptr_reg;
            result_reg.credit_left   <= credit_reg;
            result_reg.advance_total <= adv_reg;
            result_reg.skip_total    <= skip_reg;
        end
    end

endmodule

// ===== rtl/wrr_chk.sv =====
// Port-level checker for the weighted round-robin queue scheduler, with its bind.
module wrr_chk
    import wrr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sched_valid,
    input logic    sched_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sched_valid && sched_ready |=> !sched_ready)
        else $error("new transaction accepted while one is in progress");

    a_no_grant_queue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.granted |-> result.grant_queue == '0)
        else $error("grant_queue nonzero without a grant");

    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.skips_now <= NQ_W'(QUEUES))
        else $error("more skips than queues");

    a_grant_credit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.granted |-> result.credit_left != '0)
        else $error("zero credit after a grant");

endmodule

bind weighted_round_robin_queue_scheduler wrr_chk u_wrr_chk (.*);

// ===== dv/tb_weighted_round_robin_queue_scheduler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the weighted round-robin queue scheduler with its own grant predictor.
module tb_weighted_round_robin_queue_scheduler;
    import wrr_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 120;

    class sched_scoreboard;
        logic [NQ_W-1:0]      queues_in_use;
        logic [WEIGHTS_W-1:0] weights;
        logic [QIDX_W-1:0]    ptr;
        logic [CREDIT_W-1:0]  credit;
        logic [CNT_W-1:0]     grant_count;
        logic [CNT_W-1:0]     skip_count;
        result_t              expected_q[$];
        int                   errors;
        int                   checked;
        int                   grants_seen;
        int                   skips_seen;
        int                   clears_seen;

        function new();
            queues_in_use = RESET_QUEUES;
            weights       = RESET_WEIGHTS;
            errors        = 0;
            checked       = 0;
            grants_seen   = 0;
            skips_seen    = 0;
            clears_seen   = 0;
            clear_sched();
        endfunction

        function int active();
            return (queues_in_use > QUEUES) ? QUEUES : int'(queues_in_use);
        endfunction

        function logic [CREDIT_W-1:0] weight(logic [QIDX_W-1:0] q);
            logic [CREDIT_W-1:0] w;
            w = weights[int'(q) * 8 +: 8];
            return (w == '0) ? CREDIT_W'(1) : w;
        endfunction

        function void clear_sched();
            ptr         = '0;
            credit      = (active() == 0) ? '0 : weight('0);
            grant_count = '0;
            skip_count  = '0;
        endfunction

        function void advance_ptr(int n);
            ptr    = (int'(ptr) + 1 >= n) ? '0 : ptr + 1'b1;
            credit = weight(ptr);
        endfunction

        function void apply_reg(cfg_index_t idx, logic [WEIGHTS_W-1:0] data);
            if (idx == CFG_QUEUES_IN_USE)
            begin
                queues_in_use = data[NQ_W-1:0];
            end
            else
            begin
                weights = data;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_sched(sched_t item);
            result_t r;
            int      n;
            int      i;
            r = '0;
            n = active();
            if (item.cmd == CMD_CLEAR)
            begin
                clear_sched();
                clears_seen++;
            end
            else if (n != 0)
            begin
                for (i = 0; i < n; i++)
                begin
                    if (int'(ptr) < n && item.ready_mask[ptr])
                    begin
                        r.granted     = 1'b1;
                        r.grant_queue = ptr;
                        if (credit > 1)
                        begin
                            credit--;
                        end
                        else
                        begin
                            advance_ptr(n);
                        end
                        grant_count++;
                        break;
                    end
                    r.skips_now++;
                    skip_count++;
                    advance_ptr(n);
                end
            end
            r.next_queue    = ptr;
            r.credit_left   = credit;
            r.advance_total = grant_count;
            r.skip_total    = skip_count;
            grants_seen += int'(r.granted);
            skips_seen  += int'(r.skips_now);
            expected_q = {expected_q, r};
        endfunction

        function void compare(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare("granted", CNT_W'(want.granted), CNT_W'(got.granted));
            compare("grant_queue", CNT_W'(want.grant_queue), CNT_W'(got.grant_queue));
            compare("skips_now", CNT_W'(want.skips_now), CNT_W'(got.skips_now));
            compare("next_queue", CNT_W'(want.next_queue), CNT_W'(got.next_queue));
            compare("credit_left", CNT_W'(want.credit_left), CNT_W'(got.credit_left));
            compare("advance_total", want.advance_total, got.advance_total);
            compare("skip_total", want.skip_total, got.skip_total);
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sched_valid  = 1'b0;
    logic                 sched_ready;
    sched_t               sched        = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index    = CFG_QUEUES_IN_USE;
    logic [WEIGHTS_W-1:0] cfg_data     = '0;

    sched_scoreboard sb;
    bit              gaps_on = 1'b1;
    int unsigned     cycles  = 0;
    int              settings_used = 0;

    weighted_round_robin_queue_scheduler DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sched_valid  (sched_valid),
        .sched_ready  (sched_ready),
        .sched        (sched),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always
    begin
        @(posedge clk);
        if (gaps_on && rst_n && $urandom_range(0, 7) == 0)
        begin
            result_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        result_ready <= 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            sb.check_result(result);
        end
    end

    task automatic send_sched(input sched_t item);
        bit taken;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            sched_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        sched_valid <= 1'b1;
        sched       <= item;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = sched_ready;
            if (taken)
            begin
                sb.note_sched(item);
            end
            @(posedge clk);
        end
    endtask

    task automatic send(input sched_cmd_t cmd, input logic [QUEUES-1:0] mask);
        sched_t item;
        item.cmd        = cmd;
        item.ready_mask = mask;
        send_sched(item);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [WEIGHTS_W-1:0] data);
        bit taken;
        sched_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            if (taken)
            begin
                sb.apply_reg(idx, data);
            end
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic write_queues(input int n);
        logic [WEIGHTS_W-1:0] data;
        data       = {$urandom, $urandom};
        data[3:0]  = n[3:0];
        write_reg(CFG_QUEUES_IN_USE, data);
    endtask

    function automatic sched_t random_item();
        sched_t item;
        item.cmd = ($urandom_range(0, 29) == 0) ? CMD_CLEAR : CMD_SCHEDULE;
        case ($urandom_range(0, 9)) inside
            0:       item.ready_mask = '0;
            1:       item.ready_mask = '1;
            [2:3]:   item.ready_mask = QUEUES'(1) << $urandom_range(0, QUEUES - 1);
            [4:5]:   item.ready_mask = QUEUES'($urandom & $urandom);
            [6:7]:   item.ready_mask = QUEUES'($urandom | $urandom);
            default: item.ready_mask = QUEUES'($urandom);
        endcase
        return item;
    endfunction

    function automatic logic [WEIGHTS_W-1:0] random_weights();
        logic [WEIGHTS_W-1:0] w;
        int                   b;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: w = RESET_WEIGHTS;
            1: for (b = 0; b < 8; b++) w[b * 8 +: 8] = 8'($urandom_range(0, 3));
            2: for (b = 0; b < 8; b++) w[b * 8 +: 8] = 8'($urandom_range(0, 12));
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        int n_choices[9];
        int phase;
        int k;
        n_choices = '{0, 1, 2, 3, 4, 7, 8, 9, 15};
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_SCHEDULE, 8'h00);
        send(CMD_SCHEDULE, 8'hFF);
        send(CMD_SCHEDULE, 8'h80);
        send(CMD_SCHEDULE, 8'h01);
        send(CMD_CLEAR, 8'hFF);
        for (k = 1; k < 7; k++)
        begin
            send(CMD_SCHEDULE, QUEUES'(1) << k);
        end
        write_reg(CFG_QUEUE_WEIGHTS, 64'h0303_0303_0303_0303);
        send(CMD_CLEAR, 8'h00);
        send(CMD_SCHEDULE, 8'h01);
        write_reg(CFG_QUEUE_WEIGHTS, 64'hFF00_FF00_FF00_FF00);
        send(CMD_SCHEDULE, 8'h01);
        send(CMD_SCHEDULE, 8'h01);
        send(CMD_SCHEDULE, 8'h02);
        send(CMD_SCHEDULE, 8'h40);
        write_queues(3);
        send(CMD_SCHEDULE, 8'hFF);
        send(CMD_SCHEDULE, 8'hF8);
        write_queues(15);
        send(CMD_SCHEDULE, 8'h80);
        send(CMD_SCHEDULE, 8'h00);
        write_queues(0);
        send(CMD_SCHEDULE, 8'hFF);
        send(CMD_CLEAR, 8'hFF);
        send(CMD_SCHEDULE, 8'hFF);
        write_queues(1);
        send(CMD_SCHEDULE, 8'h00);
        send(CMD_SCHEDULE, 8'hFE);
        send(CMD_SCHEDULE, 8'h01);

        for (phase = 0; phase < PHASES; phase++)
        begin
            gaps_on = (phase < PHASES - 2);
            case (phase)
                0:       write_queues(8);
                1:       write_queues(15);
                2:       write_queues(1);
                default: write_queues(n_choices[$urandom_range(0, 8)]);
            endcase
            case (phase)
                0:       write_reg(CFG_QUEUE_WEIGHTS, '1);
                3:       write_reg(CFG_QUEUE_WEIGHTS, '0);
                default: write_reg(CFG_QUEUE_WEIGHTS, random_weights());
            endcase
            send(CMD_CLEAR, QUEUES'($urandom));
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                send_sched(random_item());
            end
        end

        sched_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d register settings: %0d clears, %0d grants",
                 sb.checked, settings_used, sb.clears_seen, sb.grants_seen);
        $display("and %0d skipped queues, with queue counts from 0 to 15 and weights 0 to 255.",
                 sb.skips_seen);
        if (sb.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
